@@ rtl/hwf_pkg.sv @@
// Shared constants and types for the hop window framer.
package hwf_pkg;

    localparam int WINDOW_SIZE_DEF = 64;
    localparam int RING_DEPTH_DEF  = 512;

    localparam int SAMPLE_W = 32;
    localparam int HOP_W    = 7;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // Register index taken from the word address bit of paddr
    localparam logic REG_HOP = 1'b0;

    // Input operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVAIL,
        ST_ADVANCE,
        ST_START,
        ST_ISSUE,
        ST_WAIT,
        ST_HOLD
    } state_t;

endpackage

@@ rtl/hwf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module hwf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/hop_window_framer_unit.sv @@
// Top level of the hop window framer: ring store, sequencer and shared position adder.
//
//  channel   direction  handshake             payload
//  ------    ---------  --------------------  ---------------------------------
//  in        sink       in_valid / in_ready   op, sample_in
//  out       source     out_valid / out_ready frame_ok, sample_out, last
//  apb       slave      psel/penable/pready   paddr, pwrite, pwdata, prdata
//
// A frame request checks how many samples are available, advances the read pointer by
// the hop and finds the window start, or else gives a not-available answer. Each frame
// sample needs a read issue step, a read data step and a hold step on the single RAM
// read port, and all pointer arithmetic goes through one shared adder, one step per cycle.
// Reset clears the pointers and a fill count; entries beyond the fill count read
// as zero, so no clearing pass runs and the block is ready straight after reset.
// in_ready is low from a frame request until its last transfer has left; a stall
// on out_ready holds the current result in place.
module hop_window_framer_unit #(
    parameter int WINDOW_SIZE = hwf_pkg::WINDOW_SIZE_DEF,
    parameter int RING_DEPTH  = hwf_pkg::RING_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         op,
    input  logic [hwf_pkg::SAMPLE_W-1:0] sample_in,
    // output channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         frame_ok,
    output logic [hwf_pkg::SAMPLE_W-1:0] sample_out,
    output logic                         last,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hwf_pkg::APB_AW-1:0]   paddr,
    input  logic [hwf_pkg::APB_DW-1:0]   pwdata,
    output logic [hwf_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    localparam int POS_W = $clog2(RING_DEPTH);
    localparam int CMP_W = (POS_W > hwf_pkg::HOP_W) ? POS_W : hwf_pkg::HOP_W;
    localparam int CNT_W = $clog2(WINDOW_SIZE);

    localparam logic [POS_W-1:0] WIN_OFF   = POS_W'(WINDOW_SIZE % RING_DEPTH);
    localparam logic [CNT_W-1:0] WIN_LAST  = CNT_W'(WINDOW_SIZE - 1);
    localparam logic [POS_W:0]   FILL_FULL = (POS_W + 1)'(RING_DEPTH);
    localparam logic [hwf_pkg::HOP_W-1:0] HOP_RST =
        hwf_pkg::HOP_W'((WINDOW_SIZE / 4) % (1 << hwf_pkg::HOP_W));

    hwf_pkg::state_t state_reg, state_next;

    logic [hwf_pkg::HOP_W-1:0] hop_reg;
    logic [POS_W-1:0]          write_pos_reg, write_pos_next;
    logic [POS_W-1:0]          read_pos_reg, read_pos_next;
    logic [POS_W:0]            fill_reg, fill_next;
    logic [POS_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      hit_reg, hit_next;

    logic                         frame_ok_reg, frame_ok_next;
    logic [hwf_pkg::SAMPLE_W-1:0] sample_out_reg, sample_out_next;
    logic                         last_reg, last_next;

    // shared position adder
    logic [POS_W-1:0] alu_a, alu_b, alu_sum;
    logic             alu_cin;

    logic [CMP_W-1:0] avail_ext, hop_ext;
    logic [POS_W-1:0] hop_pos;
    logic             short_of_hop;

    logic                         in_xfer, out_xfer, cfg_wr;
    logic                         ram_wr_en, ram_rd_en;
    logic [hwf_pkg::SAMPLE_W-1:0] ram_rd_data;

    assign in_ready  = (state_reg == hwf_pkg::ST_IDLE);
    assign out_valid = (state_reg == hwf_pkg::ST_HOLD);
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid && out_ready;

    assign frame_ok   = frame_ok_reg;
    assign sample_out = sample_out_reg;
    assign last       = last_reg;

    // ---------------------------------------------------------------
    // Configuration port: zero wait states, one register
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == hwf_pkg::REG_HOP);
    assign prdata = (paddr[2] == hwf_pkg::REG_HOP) ? hwf_pkg::APB_DW'(hop_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_reg <= HOP_RST;
        end
        else if (cfg_wr)
        begin
            hop_reg <= pwdata[hwf_pkg::HOP_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Shared adder: sum = a + b + cin, operands chosen per sequencer step
    // ---------------------------------------------------------------
    assign hop_ext = CMP_W'(hop_reg);
    assign hop_pos = hop_ext[POS_W-1:0];
    assign alu_sum = alu_a + alu_b + POS_W'(alu_cin);

    assign avail_ext    = CMP_W'(alu_sum);
    assign short_of_hop = (avail_ext < hop_ext);

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hwf_pkg::ST_IDLE:
            begin
                if (in_xfer && (op == hwf_pkg::OP_FRAME))
                begin
                    state_next = hwf_pkg::ST_AVAIL;
                end
            end
            hwf_pkg::ST_AVAIL:
            begin
                state_next = short_of_hop ? hwf_pkg::ST_HOLD : hwf_pkg::ST_ADVANCE;
            end
            hwf_pkg::ST_ADVANCE: state_next = hwf_pkg::ST_START;
            hwf_pkg::ST_START:   state_next = hwf_pkg::ST_ISSUE;
            hwf_pkg::ST_ISSUE:   state_next = hwf_pkg::ST_WAIT;
            hwf_pkg::ST_WAIT:    state_next = hwf_pkg::ST_HOLD;
            hwf_pkg::ST_HOLD:
            begin
                if (out_xfer)
                begin
                    state_next = last_reg ? hwf_pkg::ST_IDLE : hwf_pkg::ST_ISSUE;
                end
            end
            default: state_next = hwf_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: adder operands and RAM strobes
    // ---------------------------------------------------------------
    always_comb
    begin
        alu_a     = '0;
        alu_b     = '0;
        alu_cin   = 1'b0;
        ram_wr_en = 1'b0;
        ram_rd_en = 1'b0;
        unique case (state_reg)
            hwf_pkg::ST_IDLE:
            begin
                // advance the write pointer
                alu_a     = write_pos_reg;
                alu_cin   = 1'b1;
                ram_wr_en = in_xfer && (op == hwf_pkg::OP_WRITE);
            end
            hwf_pkg::ST_AVAIL:
            begin
                // samples written since the read pointer, wrapped
                alu_a   = write_pos_reg;
                alu_b   = ~read_pos_reg;
                alu_cin = 1'b1;
            end
            hwf_pkg::ST_ADVANCE:
            begin
                alu_a = read_pos_reg;
                alu_b = hop_pos;
            end
            hwf_pkg::ST_START:
            begin
                // window start, one window behind the new read pointer
                alu_a   = read_pos_reg;
                alu_b   = ~WIN_OFF;
                alu_cin = 1'b1;
            end
            hwf_pkg::ST_ISSUE:
            begin
                ram_rd_en = 1'b1;
            end
            hwf_pkg::ST_WAIT:
            begin
                alu_a = idx_reg;
            end
            hwf_pkg::ST_HOLD:
            begin
                alu_a   = idx_reg;
                alu_cin = 1'b1;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath next values
    // ---------------------------------------------------------------
    always_comb
    begin
        write_pos_next  = write_pos_reg;
        read_pos_next   = read_pos_reg;
        fill_next       = fill_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        hit_next        = hit_reg;
        frame_ok_next   = frame_ok_reg;
        sample_out_next = sample_out_reg;
        last_next       = last_reg;
        unique case (state_reg)
            hwf_pkg::ST_IDLE:
            begin
                if (ram_wr_en)
                begin
                    write_pos_next = alu_sum;
                    if (fill_reg != FILL_FULL)
                    begin
                        fill_next = fill_reg + (POS_W + 1)'(1);
                    end
                end
            end
            hwf_pkg::ST_AVAIL:
            begin
                if (short_of_hop)
                begin
                    frame_ok_next   = 1'b0;
                    sample_out_next = '0;
                    last_next       = 1'b1;
                end
            end
            hwf_pkg::ST_ADVANCE:
            begin
                read_pos_next = alu_sum;
            end
            hwf_pkg::ST_START:
            begin
                idx_next = alu_sum;
                cnt_next = '0;
            end
            hwf_pkg::ST_ISSUE:
            begin
                // entries at or above the fill count were never written: read as zero
                hit_next = ({1'b0, idx_reg} < fill_reg);
            end
            hwf_pkg::ST_WAIT:
            begin
                frame_ok_next   = 1'b1;
                sample_out_next = hit_reg ? ram_rd_data : '0;
                last_next       = (cnt_reg == WIN_LAST);
            end
            hwf_pkg::ST_HOLD:
            begin
                if (out_xfer && !last_reg)
                begin
                    idx_next = alu_sum;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hwf_pkg::ST_IDLE;
            write_pos_reg <= '0;
            read_pos_reg  <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            write_pos_reg <= write_pos_next;
            read_pos_reg  <= read_pos_next;
            fill_reg      <= fill_next;
        end
    end

    // payload and walk registers: no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        hit_reg        <= hit_next;
        frame_ok_reg   <= frame_ok_next;
        sample_out_reg <= sample_out_next;
        last_reg       <= last_next;
    end

    // ---------------------------------------------------------------
    // Ring store
    // ---------------------------------------------------------------
    hwf_ram #(
        .WIDTH (hwf_pkg::SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (write_pos_reg),
        .wr_data (sample_in),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

endmodule
